FILE: hdl/bhl_pkg.sv
package bhl_pkg;

    // Event kinds
    typedef logic [1:0] t_kind;
    localparam t_kind KIND_START = 2'd0;
    localparam t_kind KIND_END   = 2'd1;
    localparam t_kind KIND_CLEAR = 2'd2;
    localparam t_kind KIND_QUERY = 2'd3;

    // Field widths
    localparam int NOW_W   = 48;
    localparam int PCT_W   = 7;
    localparam int COUNT_W = 32;
    localparam int BUSY_W  = 48;
    localparam int DUTY_W  = 16;
    localparam int RATE_W  = 32;
    localparam int PCTL_W  = 32;
    localparam int BW_W    = 16;

    // Configuration port
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;
    localparam logic REG_BIN_WIDTH = 1'b0;
    localparam logic [BW_W-1:0] BW_RESET = 16'd1000;

    // Query arithmetic
    localparam logic [PCT_W-1:0] PCT_MAX    = 7'd100;
    localparam logic [9:0]       DUTY_SCALE = 10'd1000;
    localparam logic [29:0]      RATE_SCALE = 30'd1000000000;
    localparam logic [6:0]       PCT_SCALE  = 7'd100;
    localparam int TGT_W = COUNT_W + PCT_W;

    // Shared divider
    localparam int DVD_W  = 64;
    localparam int DVS_W  = 48;
    localparam int STEP_W = $clog2(DVD_W);

    // Front queue depth (power of two)
    localparam int QDEPTH = 2;

    typedef struct packed {
        t_kind            kind;
        logic [NOW_W-1:0] now_us;
        logic [PCT_W-1:0] percent;
        logic             pct_ok;
    } t_item;

    typedef struct packed {
        logic             start;
        logic [DVD_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DVD_W-1:0] quotient;
    } t_div_rsp;

endpackage

FILE: hdl/bhl_if.sv
// Event channel
interface bhl_evt_if import bhl_pkg::*; ();
    logic             valid;
    logic             ready;
    t_kind            kind;
    logic [NOW_W-1:0] now_us;
    logic [PCT_W-1:0] percent;

    modport source (output valid, kind, now_us, percent, input ready);
    modport sink (input valid, kind, now_us, percent, output ready);
endinterface

// Result channel
interface bhl_res_if import bhl_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [COUNT_W-1:0] interval_count;
    logic [BUSY_W-1:0]  busy_us;
    logic [DUTY_W-1:0]  duty_permille;
    logic [RATE_W-1:0]  rate_millihertz;
    logic [PCTL_W-1:0]  percentile_us;

    modport source (output valid, interval_count, busy_us, duty_permille, rate_millihertz,
                    percentile_us, input ready);
    modport sink (input valid, interval_count, busy_us, duty_permille, rate_millihertz,
                  percentile_us, output ready);
endinterface

FILE: hdl/bhl_ram.sv
module bhl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/bhl_front.sv
module bhl_front import bhl_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    bhl_evt_if.sink i_evt,
    output t_item o_item,
    output logic  o_item_valid,
    input  logic  i_item_ready
);

    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    t_item             r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wptr;
    logic [QPTR_W-1:0] r_rptr;
    logic [QCNT_W-1:0] r_cnt;
    t_item             item_in;
    logic              push;
    logic              pop;

    // Classify the incoming transaction
    always_comb begin
        item_in.kind    = i_evt.kind;
        item_in.now_us  = i_evt.now_us;
        item_in.percent = i_evt.percent;
        item_in.pct_ok  = (i_evt.percent <= PCT_MAX);
    end

    assign i_evt.ready  = (r_cnt != QCNT_W'(QDEPTH));
    assign push         = i_evt.valid && i_evt.ready;
    assign o_item_valid = (r_cnt != '0);
    assign pop          = o_item_valid && i_item_ready;
    assign o_item       = r_mem[r_rptr];

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (push) begin
                r_wptr <= r_wptr + QPTR_W'(1);
            end
            if (pop) begin
                r_rptr <= r_rptr + QPTR_W'(1);
            end
            case ({push, pop})
                2'b10:   r_cnt <= r_cnt + QCNT_W'(1);
                2'b01:   r_cnt <= r_cnt - QCNT_W'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    // Hold queued items
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wptr] <= item_in;
        end
    end

endmodule

FILE: hdl/bhl_div.sv
module bhl_div import bhl_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [DVS_W-1:0]  r_rem;
    logic [DVD_W-1:0]  r_quo;
    logic [DVS_W-1:0]  r_dvs;
    logic [DVS_W:0]    rem_sh;
    logic [DVS_W:0]    rem_sub;
    logic              fits;

    // One restoring step: shift in the next dividend bit, subtract if it fits
    assign rem_sh  = {r_rem, r_quo[DVD_W-1]};
    assign rem_sub = rem_sh - {1'b0, r_dvs};
    assign fits    = (rem_sh >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + STEP_W'(1);
                if (r_step == STEP_W'(DVD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Load operands, then iterate one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_quo <= i_req.dividend;
            r_dvs <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= fits ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
            r_quo <= {r_quo[DVD_W-2:0], fits};
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

FILE: hdl/bhl_back.sv
module bhl_back import bhl_pkg::*; #(
    parameter int NUM_BINS = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  t_item           i_item,
    input  logic            i_item_valid,
    output logic            o_item_ready,
    input  logic [BW_W-1:0] i_width,
    output t_div_req        o_div_req,
    input  t_div_rsp        i_div_rsp,
    bhl_res_if.source       o_res
);

    localparam int BIN_AW = $clog2(NUM_BINS);
    localparam int CUM_W  = COUNT_W + BIN_AW + 1;
    localparam int CMP_W  = CUM_W + 7;
    localparam int EDGE_W = BIN_AW + 1 + BW_W;
    localparam logic [BIN_AW-1:0] LAST_BIN = BIN_AW'(NUM_BINS - 1);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_EXEC     = 4'd1;
    localparam logic [3:0] S_END_W    = 4'd2;
    localparam logic [3:0] S_BIN_RD   = 4'd3;
    localparam logic [3:0] S_BIN_WR   = 4'd4;
    localparam logic [3:0] S_Q_DUTY   = 4'd5;
    localparam logic [3:0] S_Q_DUTY_W = 4'd6;
    localparam logic [3:0] S_Q_RATE   = 4'd7;
    localparam logic [3:0] S_Q_RATE_W = 4'd8;
    localparam logic [3:0] S_Q_TGT    = 4'd9;
    localparam logic [3:0] S_P_RD     = 4'd11;
    localparam logic [3:0] S_P_CHK    = 4'd12;
    localparam logic [3:0] S_OUT      = 4'd13;

    logic [3:0]         r_state;
    logic [3:0]         n_state;

    // Statistics
    logic [COUNT_W-1:0] r_count;
    logic [BUSY_W-1:0]  r_busy;
    logic [NOW_W-1:0]   r_wstart;
    logic [NOW_W-1:0]   r_istart;
    logic [NUM_BINS-1:0] r_bin_vld;
    logic               r_rd_vld;

    // Working registers
    t_kind              r_kind;
    logic [NOW_W-1:0]   r_now;
    logic [PCT_W-1:0]   r_pct;
    logic               r_pct_ok;
    logic [NOW_W-1:0]   r_len;
    logic [NOW_W-1:0]   r_elapsed;
    logic [DVD_W-1:0]   r_dvd;
    logic [TGT_W-1:0]   r_target;
    logic [CUM_W-1:0]   r_cum;
    logic [BIN_AW-1:0]  r_idx;
    logic [DUTY_W-1:0]  r_duty;
    logic [RATE_W-1:0]  r_rate;
    logic [PCTL_W-1:0]  r_pctl;

    // Result register
    logic               r_out_valid;
    logic [COUNT_W-1:0] r_out_count;
    logic [BUSY_W-1:0]  r_out_busy;
    logic [DUTY_W-1:0]  r_out_duty;
    logic [RATE_W-1:0]  r_out_rate;
    logic [PCTL_W-1:0]  r_out_pctl;

    logic [NOW_W-1:0]   len;
    logic [NOW_W-1:0]   elapsed;
    logic [COUNT_W-1:0] ram_rdata;
    logic [COUNT_W-1:0] bin_val;
    logic [BIN_AW-1:0]  bin_sel;
    logic [CUM_W-1:0]   cum_n;
    logic               hit;
    logic [BIN_AW:0]    idx_p1;
    logic [EDGE_W-1:0]  bin_edge;
    logic               ram_we;
    logic               out_take;
    logic               duty_go;
    logic               rate_go;
    logic               tgt_go;

    assign len     = r_now - r_istart;
    assign elapsed = r_now - r_wstart;

    assign duty_go = (r_count != '0) && (r_elapsed != '0);
    assign rate_go = (r_elapsed != '0);
    assign tgt_go  = r_pct_ok && (r_count != '0);

    // Clamp the quotient to the last bin
    assign bin_sel = (i_div_rsp.quotient > DVD_W'(NUM_BINS - 1)) ?
                     LAST_BIN : i_div_rsp.quotient[BIN_AW-1:0];

    // Bin store: an entry never written reads as zero
    bhl_ram #(
        .WIDTH (COUNT_W),
        .DEPTH (NUM_BINS)
    ) u_bins (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_idx),
        .i_wdata (bin_val + COUNT_W'(1)),
        .i_raddr (r_idx),
        .o_rdata (ram_rdata)
    );

    assign bin_val  = r_rd_vld ? ram_rdata : '0;
    assign ram_we   = (r_state == S_BIN_WR);

    // Percentile walk: the running sum reaches ceil(count*percent/100) exactly when a
    // hundred times the sum reaches count*percent
    assign cum_n    = r_cum + CUM_W'(bin_val);
    assign hit      = ((CMP_W'(cum_n) * CMP_W'(PCT_SCALE)) >= CMP_W'(r_target));
    assign idx_p1   = {1'b0, r_idx} + (BIN_AW + 1)'(1);
    assign bin_edge = EDGE_W'(idx_p1) * EDGE_W'(i_width);

    // Divider requests
    always_comb begin
        o_div_req.start = ((r_state == S_EXEC) && (r_kind == KIND_END)) ||
                          ((r_state == S_Q_DUTY) && duty_go) ||
                          ((r_state == S_Q_RATE) && rate_go);
        o_div_req.dividend = (r_state == S_EXEC) ? DVD_W'(len) : r_dvd;
        case (r_state)
            S_EXEC:  o_div_req.divisor = DVS_W'(i_width);
            default: o_div_req.divisor = r_elapsed;
        endcase
    end

    assign o_item_ready = (r_state == S_IDLE);
    assign out_take     = !r_out_valid || o_res.ready;

    // Sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_item_valid) n_state = S_EXEC;
            end
            S_EXEC: begin
                case (r_kind)
                    KIND_END:   n_state = S_END_W;
                    KIND_QUERY: n_state = S_Q_DUTY;
                    default:    n_state = S_IDLE;
                endcase
            end
            S_END_W: begin
                if (i_div_rsp.done) n_state = S_BIN_RD;
            end
            S_BIN_RD:   n_state = S_BIN_WR;
            S_BIN_WR:   n_state = S_IDLE;
            S_Q_DUTY:   n_state = duty_go ? S_Q_DUTY_W : S_Q_RATE;
            S_Q_DUTY_W: begin
                if (i_div_rsp.done) n_state = S_Q_RATE;
            end
            S_Q_RATE:   n_state = rate_go ? S_Q_RATE_W : S_Q_TGT;
            S_Q_RATE_W: begin
                if (i_div_rsp.done) n_state = S_Q_TGT;
            end
            S_Q_TGT:    n_state = tgt_go ? S_P_RD : S_OUT;
            S_P_RD:     n_state = S_P_CHK;
            S_P_CHK: begin
                if (hit || (r_idx == LAST_BIN)) n_state = S_OUT;
                else n_state = S_P_RD;
            end
            S_OUT: begin
                if (out_take) n_state = S_IDLE;
            end
            default:    n_state = S_IDLE;
        endcase
    end

    // Control and statistics
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_busy      <= '0;
            r_wstart    <= '0;
            r_istart    <= '0;
            r_bin_vld   <= '0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= r_bin_vld[r_idx];
            if ((r_state == S_EXEC) && (r_kind == KIND_START)) begin
                if (r_count == '0) r_wstart <= r_now;
                r_istart <= r_now;
            end
            if ((r_state == S_EXEC) && (r_kind == KIND_CLEAR)) begin
                r_count  <= '0;
                r_busy   <= '0;
                r_wstart <= '0;
                r_istart <= '0;
            end
            if (r_state == S_BIN_WR) begin
                r_busy           <= r_busy + r_len;
                r_count          <= r_count + COUNT_W'(1);
                r_bin_vld[r_idx] <= 1'b1;
            end
            if ((r_state == S_OUT) && out_take) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Working data path
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (i_item_valid) begin
                    r_kind   <= i_item.kind;
                    r_now    <= i_item.now_us;
                    r_pct    <= i_item.percent;
                    r_pct_ok <= i_item.pct_ok;
                end
            end
            S_EXEC: begin
                r_len     <= len;
                r_elapsed <= elapsed;
                r_dvd     <= DVD_W'(r_busy) * DVD_W'(DUTY_SCALE);
            end
            S_END_W: begin
                if (i_div_rsp.done) r_idx <= bin_sel;
            end
            S_Q_DUTY: begin
                r_duty <= '0;
                r_dvd  <= DVD_W'(r_count) * DVD_W'(RATE_SCALE);
            end
            S_Q_DUTY_W: begin
                if (i_div_rsp.done) r_duty <= i_div_rsp.quotient[DUTY_W-1:0];
            end
            S_Q_RATE: begin
                r_rate <= '0;
            end
            S_Q_RATE_W: begin
                if (i_div_rsp.done) r_rate <= i_div_rsp.quotient[RATE_W-1:0];
            end
            S_Q_TGT: begin
                r_pctl   <= '0;
                r_cum    <= '0;
                r_idx    <= '0;
                r_target <= TGT_W'(r_count) * TGT_W'(r_pct);
            end
            S_P_CHK: begin
                r_cum <= cum_n;
                if (hit || (r_idx == LAST_BIN)) begin
                    r_pctl <= PCTL_W'(bin_edge);
                end else begin
                    r_idx <= r_idx + BIN_AW'(1);
                end
            end
            S_OUT: begin
                if (out_take) begin
                    r_out_count <= r_count;
                    r_out_busy  <= r_busy;
                    r_out_duty  <= r_duty;
                    r_out_rate  <= r_rate;
                    r_out_pctl  <= r_pctl;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_res.valid           = r_out_valid;
    assign o_res.interval_count  = r_out_count;
    assign o_res.busy_us         = r_out_busy;
    assign o_res.duty_permille   = r_out_duty;
    assign o_res.rate_millihertz = r_out_rate;
    assign o_res.percentile_us   = r_out_pctl;

endmodule

FILE: hdl/busy_time_latency_histogram_core.sv
// Start and clear events are handled in the sequencer's execute state; an end event also waits
// on the bit-serial divider that picks the bin, then does a read-modify-write of the bin.
// A query runs up to two passes of the same divider and a walk over the bin memory with a
// read state and a check state per bin. One event is worked on at a time; a two-entry
// queue and the result register let both channels move while the sequencer is busy.
// Synchronous reset clears the statistics and bin valid bits and sets the bin width to 1000.
module busy_time_latency_histogram_core import bhl_pkg::*; #(
    parameter int NUM_BINS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_psel,
    input  logic              i_penable,
    input  logic              i_pwrite,
    input  logic [APB_AW-1:0] i_paddr,
    input  logic [APB_DW-1:0] i_pwdata,
    output logic [APB_DW-1:0] o_prdata,
    output logic              o_pready,
    bhl_evt_if.sink           i_evt,
    bhl_res_if.source         o_res
);

    logic [BW_W-1:0] r_bin_width;
    logic [BW_W-1:0] width_eff;
    logic            reg_sel;
    t_item           item;
    logic            item_valid;
    logic            item_ready;
    t_div_req        div_req;
    t_div_rsp        div_rsp;

    // Register file: word index picks the register
    assign reg_sel  = (i_paddr[2] == REG_BIN_WIDTH);
    assign o_pready = 1'b1;
    assign o_prdata = reg_sel ? APB_DW'(r_bin_width) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bin_width <= BW_RESET;
        end else if (i_psel && i_penable && i_pwrite && reg_sel) begin
            r_bin_width <= i_pwdata[BW_W-1:0];
        end
    end

    // Treat a zero width as one
    assign width_eff = (r_bin_width == '0) ? BW_W'(1) : r_bin_width;

    bhl_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_evt        (i_evt),
        .o_item       (item),
        .o_item_valid (item_valid),
        .i_item_ready (item_ready)
    );

    bhl_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    bhl_back #(
        .NUM_BINS (NUM_BINS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (item),
        .i_item_valid (item_valid),
        .o_item_ready (item_ready),
        .i_width      (width_eff),
        .o_div_req    (div_req),
        .i_div_rsp    (div_rsp),
        .o_res        (o_res)
    );

endmodule

FILE: bench/busy_time_latency_histogram_core_tb.sv
module busy_time_latency_histogram_core_tb;
    import bhl_pkg::*;

    localparam int NUM_BINS      = 16;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 300;
    localparam int RANDOM_EVENTS = 92;
    localparam int NUM_PHASES    = 6;

    localparam logic [APB_AW-1:0] BIN_WIDTH_ADDR = APB_AW'(REG_BIN_WIDTH) << 2;
    localparam logic [APB_AW-1:0] UNUSED_ADDR    = BIN_WIDTH_ADDR + APB_AW'(4);

    typedef struct {
        t_kind            kind;
        logic [NOW_W-1:0] now_us;
        logic [PCT_W-1:0] percent;
    } t_timed_event;

    typedef struct {
        logic [COUNT_W-1:0] interval_count;
        logic [BUSY_W-1:0]  busy_us;
        logic [DUTY_W-1:0]  duty_permille;
        logic [RATE_W-1:0]  rate_millihertz;
        logic [PCTL_W-1:0]  percentile_us;
    } t_usage_report;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    // Configuration port
    logic              psel    = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite  = 1'b0;
    logic [APB_AW-1:0] paddr   = '0;
    logic [APB_DW-1:0] pwdata  = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    bhl_evt_if evt_bus ();
    bhl_res_if res_bus ();

    busy_time_latency_histogram_core #(
        .NUM_BINS (NUM_BINS)
    ) DUT (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_prdata  (prdata),
        .o_pready  (pready),
        .i_evt     (evt_bus),
        .o_res     (res_bus)
    );

    // Mirror of the monitor state
    logic [BW_W-1:0]    bin_width      = BW_RESET;
    logic [COUNT_W-1:0] intervals_done = '0;
    logic [BUSY_W-1:0]  busy_sum       = '0;
    logic [NOW_W-1:0]   window_from    = '0;
    logic [NOW_W-1:0]   interval_from  = '0;
    logic [COUNT_W-1:0] bin_hits [NUM_BINS] = '{default: '0};

    t_timed_event  queued_events [$];
    t_usage_report expected_reports [$];

    int idle_pct        = 0;
    int events_queued   = 0;
    int events_accepted = 0;
    int queries_seen    = 0;
    int reports_checked = 0;
    int mismatch_count  = 0;
    int cycle_count     = 0;
    int gap_left        = 0;
    int stall_left      = 0;
    logic [NOW_W-1:0] stamp_us = '0;

    always #5 i_clk = ~i_clk;

    task automatic flag_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
        $display("MISMATCH %s: got 0x%0h, expected 0x%0h (report %0d)", what, got, want,
                 reports_checked);
        mismatch_count++;
    endtask

    // Apply one accepted event to the mirror; queries produce an expected report
    task automatic track_event(input t_kind kind, input logic [NOW_W-1:0] now,
                               input logic [PCT_W-1:0] pct);
        logic [63:0]      w;
        logic [63:0]      wide;
        logic [63:0]      target;
        logic [63:0]      running;
        logic [63:0]      edge_us;
        logic [NOW_W-1:0] span;
        int               bin_idx;
        bit               hit;
        t_usage_report    rpt;
        w = (bin_width == '0) ? 64'd1 : 64'(bin_width);
        case (kind)
            KIND_START: begin
                if (intervals_done == '0) window_from = now;
                interval_from = now;
            end
            KIND_END: begin
                span = now - interval_from;
                wide = {16'b0, span} / w;
                bin_idx = (wide > 64'(NUM_BINS - 1)) ? NUM_BINS - 1 : int'(wide);
                busy_sum = busy_sum + span;
                intervals_done = intervals_done + 1'b1;
                bin_hits[bin_idx] = bin_hits[bin_idx] + 1'b1;
            end
            KIND_CLEAR: begin
                intervals_done = '0;
                busy_sum = '0;
                window_from = '0;
                interval_from = '0;
            end
            default: begin
                span = now - window_from;
                rpt.interval_count  = intervals_done;
                rpt.busy_us         = busy_sum;
                rpt.duty_permille   = '0;
                rpt.rate_millihertz = '0;
                rpt.percentile_us   = '0;
                if (span != '0) begin
                    if (intervals_done != '0) begin
                        wide = ({16'b0, busy_sum} * 64'd1000) / {16'b0, span};
                        rpt.duty_permille = wide[DUTY_W-1:0];
                    end
                    wide = ({32'b0, intervals_done} * 64'd1000000000) / {16'b0, span};
                    rpt.rate_millihertz = wide[RATE_W-1:0];
                end
                // Walk the bins until the running sum covers the requested share
                if (pct <= PCT_MAX && intervals_done != '0) begin
                    target = ({32'b0, intervals_done} * 64'(pct) + 64'd99) / 64'd100;
                    running = '0;
                    hit = 1'b0;
                    edge_us = 64'(NUM_BINS) * w;
                    for (int i = 0; i < NUM_BINS; i++) begin
                        if (!hit) begin
                            running = running + 64'(bin_hits[i]);
                            if (running >= target) begin
                                edge_us = 64'(i + 1) * w;
                                hit = 1'b1;
                            end
                        end
                    end
                    rpt.percentile_us = edge_us[PCTL_W-1:0];
                end
                expected_reports.push_back(rpt);
                queries_seen++;
            end
        endcase
    endtask

    task automatic queue_event(input t_kind kind, input logic [NOW_W-1:0] now,
                               input logic [PCT_W-1:0] pct);
        t_timed_event ev;
        ev.kind = kind;
        ev.now_us = now;
        ev.percent = pct;
        queued_events.push_back(ev);
        events_queued++;
    endtask

    // Mostly valid percentiles, with some above the limit
    function automatic logic [PCT_W-1:0] pick_percent();
        if ($urandom_range(0, 99) < 15) return PCT_W'($urandom_range(101, 127));
        return PCT_W'($urandom_range(0, 100));
    endfunction

    // Mostly start/end pairs on a rising time base, with queries, clears and noise
    task automatic queue_random_events(input int count);
        int               made;
        int               roll;
        logic [31:0]      max_len;
        logic [NOW_W-1:0] span;
        made = 0;
        max_len = (bin_width == '0) ? 32'd17 : 32'd17 * 32'(bin_width);
        while (made < count) begin
            roll = $urandom_range(0, 99);
            if (roll < 58) begin
                stamp_us = stamp_us + NOW_W'($urandom_range(0, 5000));
                queue_event(KIND_START, stamp_us, PCT_W'($urandom_range(0, 127)));
                if ($urandom_range(0, 19) == 0) span = NOW_W'({$urandom, $urandom});
                else span = NOW_W'($urandom_range(0, max_len));
                stamp_us = stamp_us + span;
                queue_event(KIND_END, stamp_us, PCT_W'($urandom_range(0, 127)));
                made += 2;
            end else if (roll < 80) begin
                stamp_us = stamp_us + NOW_W'($urandom_range(0, 3000));
                queue_event(KIND_QUERY, stamp_us, pick_percent());
                made++;
            end else if (roll < 85) begin
                queue_event(KIND_CLEAR, stamp_us, PCT_W'($urandom_range(0, 127)));
                made++;
            end else begin
                queue_event(t_kind'($urandom_range(0, 3)), NOW_W'({$urandom, $urandom}),
                            PCT_W'($urandom_range(0, 127)));
                made++;
            end
        end
    endtask

    task automatic cfg_write(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (addr == BIN_WIDTH_ADDR) bin_width = data[BW_W-1:0];
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic cfg_check_width();
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= BIN_WIDTH_ADDR;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== APB_DW'(bin_width)) flag_mismatch("bin width readback", prdata, bin_width);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Wait for every queued event to be taken and every report to come back
    task automatic drain_and_settle();
        while (events_accepted != events_queued) @(posedge i_clk);
        while (expected_reports.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Event driver: hold each transaction until taken, with random gaps between
    always @(posedge i_clk) begin : event_driver
        t_timed_event next_ev;
        if (!i_rst_n) begin
            evt_bus.valid <= 1'b0;
        end else begin
            if (evt_bus.valid && evt_bus.ready) begin
                track_event(evt_bus.kind, evt_bus.now_us, evt_bus.percent);
                events_accepted++;
            end
            if (!evt_bus.valid || evt_bus.ready) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    evt_bus.valid <= 1'b0;
                end else if (queued_events.size() != 0 && idle_pct > 0 &&
                             $urandom_range(0, 99) < idle_pct) begin
                    gap_left <= $urandom_range(0, 17);
                    evt_bus.valid <= 1'b0;
                end else if (queued_events.size() != 0) begin
                    next_ev = queued_events.pop_front();
                    evt_bus.valid   <= 1'b1;
                    evt_bus.kind    <= next_ev.kind;
                    evt_bus.now_us  <= next_ev.now_us;
                    evt_bus.percent <= next_ev.percent;
                end else begin
                    evt_bus.valid <= 1'b0;
                end
            end
        end
    end

    // Report monitor: compare each transaction with the oldest expectation, stall at random
    always @(posedge i_clk) begin : report_monitor
        t_usage_report want;
        if (i_rst_n && res_bus.valid && res_bus.ready) begin
            if (expected_reports.size() == 0) begin
                flag_mismatch("report with none outstanding", res_bus.interval_count, 0);
            end else begin
                want = expected_reports.pop_front();
                if (res_bus.interval_count !== want.interval_count)
                    flag_mismatch("interval_count", res_bus.interval_count, want.interval_count);
                if (res_bus.busy_us !== want.busy_us)
                    flag_mismatch("busy_us", res_bus.busy_us, want.busy_us);
                if (res_bus.duty_permille !== want.duty_permille)
                    flag_mismatch("duty_permille", res_bus.duty_permille, want.duty_permille);
                if (res_bus.rate_millihertz !== want.rate_millihertz)
                    flag_mismatch("rate_millihertz", res_bus.rate_millihertz,
                                  want.rate_millihertz);
                if (res_bus.percentile_us !== want.percentile_us)
                    flag_mismatch("percentile_us", res_bus.percentile_us, want.percentile_us);
                reports_checked++;
            end
        end
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            res_bus.ready <= 1'b0;
        end else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
            stall_left <= $urandom_range(0, 17);
            res_bus.ready <= 1'b0;
        end else begin
            res_bus.ready <= 1'b1;
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        logic [BW_W-1:0] width_plan [NUM_PHASES];
        int              idle_plan  [NUM_PHASES];
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset width, then directed corners
        cfg_check_width();
        idle_pct = 25;
        queue_event(KIND_QUERY, 48'h0, 7'd50);                 // nothing yet, no elapsed time
        queue_event(KIND_QUERY, 48'hFFFF_FFFF_FFFF, 7'd127);
        queue_event(KIND_START, 48'd100, 7'd0);
        queue_event(KIND_END, 48'd100, 7'd127);                // zero length
        queue_event(KIND_START, 48'd1000, 7'd0);
        queue_event(KIND_END, 48'd2500, 7'd0);
        queue_event(KIND_START, 48'd5000, 7'd0);
        queue_event(KIND_END, 48'd25000, 7'd0);                // beyond the last bin
        queue_event(KIND_QUERY, 48'd30000, 7'd0);
        queue_event(KIND_QUERY, 48'd30000, 7'd100);
        queue_event(KIND_QUERY, 48'd30000, 7'd101);
        queue_event(KIND_QUERY, 48'd100, 7'd50);               // window of zero length
        queue_event(KIND_START, 48'hFFFF_FFFF_F000, 7'd0);
        queue_event(KIND_END, 48'h500, 7'd0);                  // timestamp wraps
        queue_event(KIND_START, 48'h0, 7'd0);
        queue_event(KIND_END, 48'hFFFF_FFFF_FFFF, 7'd0);       // busy total wraps
        queue_event(KIND_QUERY, 48'd101, 7'd99);               // duty and rate truncate
        queue_event(KIND_END, 48'd7, 7'd0);                    // end with no fresh start
        queue_event(KIND_QUERY, 48'h7FFF_FFFF_FFFF, 7'd33);
        queue_event(KIND_CLEAR, 48'hAAAA_5555_AAAA, 7'd85);
        queue_event(KIND_QUERY, 48'd12345, 7'd100);            // cleared, bins kept
        queue_event(KIND_START, 48'd10, 7'd0);
        queue_event(KIND_END, 48'd20, 7'd0);
        queue_event(KIND_QUERY, 48'd30, 7'd100);
        queue_event(KIND_QUERY, 48'd30, 7'd1);
        drain_and_settle();

        // A write to an unmapped address must leave the width alone
        cfg_write(UNUSED_ADDR, $urandom);
        cfg_check_width();

        width_plan = '{16'd1, 16'd65535, 16'd0, BW_W'($urandom_range(2, 65534)),
                       BW_W'($urandom_range(2, 65534)), BW_RESET};
        idle_plan  = '{20, 40, 0, 10, 50, 0};
        for (int p = 0; p < NUM_PHASES; p++) begin
            cfg_write(BIN_WIDTH_ADDR, {16'($urandom), width_plan[p]});
            cfg_check_width();
            idle_pct = idle_plan[p];
            // Start one phase just short of the timestamp wrap
            stamp_us = (p == 3) ? 48'hFFFF_FFFF_0000 : NOW_W'({$urandom, $urandom});
            queue_random_events(RANDOM_EVENTS);
            drain_and_settle();
        end

        $display("Checked %0d reports from %0d queries over %0d events in total.",
                 reports_checked, queries_seen, events_accepted);
        $display("Bin widths covered the reset value, one, the maximum and zero taken as one.");
        if (mismatch_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
